### src/i488_pkg.sv
// shared types, codes and helpers for the ieee-488 device handshake
`default_nettype none
package i488_pkg;

	// line positions inside the 15-bit drive word
	localparam int unsigned LN_EOI        = 0;
	localparam int unsigned LN_DAV        = 1;
	localparam int unsigned LN_NRFD       = 2;
	localparam int unsigned LN_NDAC       = 3;
	localparam int unsigned LN_DATA_SHIFT = 7;
	localparam int unsigned LINE_W        = 15;

	// command byte fields
	localparam logic [7:0] OPC_MASK     = 8'hf0;
	localparam logic [7:0] ARG_MASK     = 8'h0f;
	localparam logic [7:0] OPC_LISTEN   = 8'h20;
	localparam logic [7:0] OPC_UNLISTEN = 8'h30;
	localparam logic [7:0] OPC_TALK     = 8'h40;
	localparam logic [7:0] OPC_UNTALK   = 8'h50;
	localparam logic [7:0] OPC_SECOND   = 8'h60;
	localparam logic [7:0] OPC_CLOSE    = 8'he0;
	localparam logic [7:0] OPC_OPEN     = 8'hf0;

	// configuration register indexes
	localparam logic REG_DEVICE_ADDRESS = 1'b0;
	localparam logic REG_FORCE_LOW_MASK = 1'b1;

	localparam logic [3:0]  DEVICE_ADDRESS_RST = 4'd8;

	// comm_mode output codes
	localparam logic [2:0] CMODE_IDLE       = 3'd0;
	localparam logic [2:0] CMODE_LISTEN     = 3'd1;
	localparam logic [2:0] CMODE_START_TALK = 3'd2;
	localparam logic [2:0] CMODE_TALK       = 3'd3;
	localparam logic [2:0] CMODE_OPENING    = 3'd4;

	typedef enum logic [8:0] {
		PH_IDLE      = 9'b000000001,
		PH_ACC_START = 9'b000000010,
		PH_ACC_READY = 9'b000000100,
		PH_ACC_AVAIL = 9'b000001000,
		PH_ACC_TAKEN = 9'b000010000,
		PH_SRC_START = 9'b000100000,
		PH_SRC_READY = 9'b001000000,
		PH_SRC_VALID = 9'b010000000,
		PH_SRC_TAKEN = 9'b100000000
	} bus_phase_t;

	typedef enum logic [4:0] {
		CM_IDLE       = 5'b00001,
		CM_LISTEN     = 5'b00010,
		CM_START_TALK = 5'b00100,
		CM_TALK       = 5'b01000,
		CM_OPENING    = 5'b10000
	} comm_phase_t;

	// channel table update requests for one transfer
	typedef struct packed {
		logic       clear_all;
		logic       open_en;
		logic       close_en;
		logic       name_inc;
		logic [3:0] chan;
	} chan_req_t;

	function automatic logic [2:0] comm_code(input comm_phase_t cm);
		logic [2:0] code;
		case (cm)
			CM_LISTEN:     code = CMODE_LISTEN;
			CM_START_TALK: code = CMODE_START_TALK;
			CM_TALK:       code = CMODE_TALK;
			CM_OPENING:    code = CMODE_OPENING;
			default:       code = CMODE_IDLE;
		endcase
		return code;
	endfunction

	// bus filename byte to ascii, zero when unmapped
	function automatic logic [6:0] to_text(input logic [7:0] c);
		logic [6:0] r;
		r = 7'd0;
		if (c >= 8'h20 && c <= 8'h5b) r = c[6:0];
		else if (c == 8'h5d) r = c[6:0];
		else if (c == 8'ha0) r = 7'h20;
		return r;
	endfunction

endpackage
`default_nettype wire

### src/ieee488_device_handshake.sv
// ieee-488 device handshake: one bus sample per transfer in, one result per transfer out
// the result of a sample is registered and shown in the cycle after its transfer is taken
// throughput: one sample per cycle; the bus state machine updates once per sample
// a waiting result holds off input; a new sample goes in on the edge that drains it
// reset (arst_n low): bus and comm phases idle, all lines released, channels closed,
// device_address 8, force_low_mask 0
`default_nettype none
module ieee488_device_handshake import i488_pkg::*; #(
	parameter int NUM_CHANNELS = 16,
	parameter int NAME_MAX     = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [14:0] cfg_data,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic        ifc_asserted,
	input  wire logic        atn_asserted,
	input  wire logic        dav_asserted,
	input  wire logic        nrfd_asserted,
	input  wire logic        ndac_asserted,
	input  wire logic [7:0]  bus_byte,
	input  wire logic [7:0]  source_byte,
	input  wire logic        source_has_byte,
	input  wire logic        source_is_last,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [6:0]  drive_control,
	output      logic [7:0]  drive_data,
	output      logic [6:0]  name_char,
	output      logic        name_char_valid,
	output      logic [3:0]  name_position,
	output      logic [3:0]  channel_now,
	output      logic        load_request,
	output      logic        source_advance,
	output      logic [2:0]  comm_mode
);

	localparam int LW = $clog2(NAME_MAX + 1);

	logic [3:0]        dev_addr_q;
	logic [14:0]       force_q;

	bus_phase_t        phase_q, phase_d, phase_eff;
	comm_phase_t       comm_q, comm_d;
	logic [3:0]        chan_q, chan_d;
	logic              prev_atn_q, prev_ifc_q;
	logic [LINE_W-1:0] line_q, line_d;
	logic              sent_last_q, sent_last_d;

	logic              accept;
	logic              atn_rise, ifc_rise;
	logic              chan_in_range, arg_in_range;
	logic [7:0]        opc;
	logic [3:0]        arg;
	logic [LW-1:0]     fname_cnt;
	chan_req_t         req;
	logic [14:0]       all_drive;

	logic [6:0]        nchar_d;
	logic              nvalid_d;
	logic [3:0]        npos_d;
	logic              load_d, adv_d;

	assign accept   = in_valid && in_ready;
	assign in_ready = !out_valid || out_ready;

	assign atn_rise      = atn_asserted && !prev_atn_q;
	assign ifc_rise      = ifc_asserted && !prev_ifc_q;
	assign opc           = bus_byte & OPC_MASK;
	assign arg           = 4'(bus_byte & ARG_MASK);
	assign chan_in_range = {1'b0, chan_q} < 5'(NUM_CHANNELS);
	assign arg_in_range  = {1'b0, arg} < 5'(NUM_CHANNELS);
	assign phase_eff     = atn_rise ? PH_ACC_START : phase_q;

	i488_chan #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.NAME_MAX    (NAME_MAX)
	) u_chan (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (accept),
		.req         (req),
		.rd_chan     (chan_q),
		.rd_fname_cnt(fname_cnt)
	);

	always_comb begin
		phase_d     = phase_q;
		comm_d      = comm_q;
		chan_d      = chan_q;
		line_d      = line_q;
		sent_last_d = sent_last_q;
		req         = '0;
		req.chan    = chan_q;
		nchar_d     = 7'd0;
		nvalid_d    = 1'b0;
		npos_d      = 4'd0;
		load_d      = 1'b0;
		adv_d       = 1'b0;

		if (ifc_rise) begin
			phase_d       = PH_IDLE;
			comm_d        = CM_IDLE;
			chan_d        = 4'd0;
			line_d        = '0;
			sent_last_d   = 1'b0;
			req.clear_all = 1'b1;
		end else begin
			case (phase_eff)
				PH_ACC_START: begin
					line_d[LN_NRFD] = 1'b1;
					line_d[LN_NDAC] = 1'b1;
					phase_d = PH_ACC_READY;
				end
				PH_ACC_READY: begin
					line_d[LN_NRFD] = 1'b0;
					if (dav_asserted) phase_d = PH_ACC_AVAIL;
				end
				PH_ACC_AVAIL: begin
					line_d[LN_NRFD] = 1'b1;
					if (atn_asserted) begin
						case (opc)
							OPC_LISTEN: begin
								if (arg == dev_addr_q) comm_d = CM_LISTEN;
							end
							OPC_UNLISTEN, OPC_UNTALK: begin
								comm_d = CM_IDLE;
							end
							OPC_TALK: begin
								if (arg == dev_addr_q) comm_d = CM_START_TALK;
							end
							OPC_SECOND: begin
								if (comm_q == CM_LISTEN) begin
									chan_d = arg;
								end else if (comm_q == CM_START_TALK) begin
									chan_d = arg;
									load_d = 1'b1;
									comm_d = CM_TALK;
								end
							end
							OPC_CLOSE: begin
								if (comm_q == CM_LISTEN && chan_in_range) req.close_en = 1'b1;
							end
							OPC_OPEN: begin
								if (comm_q == CM_LISTEN) begin
									chan_d      = arg;
									comm_d      = CM_OPENING;
									req.chan    = arg;
									req.open_en = arg_in_range;
								end
							end
							default: begin
								// unknown commands are ignored
							end
						endcase
					end else if (comm_q == CM_OPENING && chan_in_range) begin
						if (fname_cnt < LW'(NAME_MAX)) begin
							nchar_d      = to_text(bus_byte);
							nvalid_d     = 1'b1;
							npos_d       = 4'(fname_cnt);
							req.name_inc = 1'b1;
						end
					end
					line_d[LN_NDAC] = 1'b0;
					phase_d = PH_ACC_TAKEN;
				end
				PH_ACC_TAKEN: begin
					if (!dav_asserted) begin
						line_d[LN_NDAC] = 1'b1;
						if (comm_q == CM_TALK) phase_d = PH_SRC_START;
						else if (comm_q != CM_IDLE) phase_d = PH_ACC_READY;
						else phase_d = PH_IDLE;
					end
				end
				PH_SRC_START: begin
					line_d[LN_DAV]  = 1'b0;
					line_d[LN_NRFD] = 1'b0;
					line_d[LN_NDAC] = 1'b0;
					if (atn_asserted) phase_d = PH_SRC_START;
					else if (!nrfd_asserted && !ndac_asserted) phase_d = PH_IDLE;
					else phase_d = PH_SRC_READY;
				end
				PH_SRC_READY: begin
					if (!source_has_byte) begin
						phase_d = PH_IDLE;
						comm_d  = CM_IDLE;
					end else begin
						line_d[LINE_W-1:LN_DATA_SHIFT] = source_byte;
						if (source_is_last) begin
							line_d[LN_EOI] = 1'b1;
							sent_last_d    = 1'b1;
						end
						if (!nrfd_asserted) phase_d = PH_SRC_VALID;
					end
				end
				PH_SRC_VALID: begin
					line_d[LN_DAV] = 1'b1;
					if (!ndac_asserted) phase_d = PH_SRC_TAKEN;
				end
				PH_SRC_TAKEN: begin
					line_d[LN_DAV] = 1'b0;
					line_d[LN_EOI] = 1'b0;
					line_d[LINE_W-1:LN_DATA_SHIFT] = 8'd0;
					adv_d = 1'b1;
					if (sent_last_q) begin
						phase_d = PH_IDLE;
						comm_d  = CM_IDLE;
					end else begin
						phase_d = PH_SRC_READY;
					end
					sent_last_d = 1'b0;
				end
				default: begin
					// idle and any stray code
					phase_d = PH_IDLE;
					line_d[LN_NRFD] = 1'b0;
					line_d[LN_NDAC] = 1'b0;
				end
			endcase
		end
	end

	assign all_drive = line_d | force_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEVICE_ADDRESS_RST;
			force_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEVICE_ADDRESS: dev_addr_q <= cfg_data[3:0];
				REG_FORCE_LOW_MASK: force_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			comm_q      <= CM_IDLE;
			chan_q      <= 4'd0;
			prev_atn_q  <= 1'b0;
			prev_ifc_q  <= 1'b0;
			line_q      <= '0;
			sent_last_q <= 1'b0;
		end else if (accept) begin
			phase_q     <= phase_d;
			comm_q      <= comm_d;
			chan_q      <= chan_d;
			prev_atn_q  <= atn_asserted;
			prev_ifc_q  <= ifc_asserted;
			line_q      <= line_d;
			sent_last_q <= sent_last_d;
		end
	end

	// result register, refilled on the same edge it is drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (accept) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			drive_control   <= all_drive[6:0];
			drive_data      <= all_drive[14:7];
			name_char       <= nchar_d;
			name_char_valid <= nvalid_d;
			name_position   <= npos_d;
			channel_now     <= chan_d;
			load_request    <= load_d;
			source_advance  <= adv_d;
			comm_mode       <= comm_code(comm_d);
		end
	end

`ifndef SYNTH
	a_load_in_talk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && load_request |-> comm_mode == CMODE_TALK)
		else $error("load request outside talk mode");

	a_name_in_opening: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && name_char_valid |-> comm_mode == CMODE_OPENING)
		else $error("filename character outside opening mode");

	a_advance_clears_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && source_advance |-> drive_data == force_q[14:7])
		else $error("data lines still driven after sent byte accepted");

	a_ifc_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ifc_rise |=> phase_q == PH_IDLE && comm_q == CM_IDLE && line_q == '0)
		else $error("interface clear did not reset the bus state");
`endif

endmodule
`default_nettype wire

### src/i488_chan.sv
// per-channel open flags and filename lengths
`default_nettype none
module i488_chan import i488_pkg::*; #(
	parameter int NUM_CHANNELS = 16,
	parameter int NAME_MAX     = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              upd,
	input  wire chan_req_t                         req,
	input  wire logic [3:0]                        rd_chan,
	output      logic [$clog2(NAME_MAX + 1) - 1:0] rd_fname_cnt
);

	localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int LW = $clog2(NAME_MAX + 1);

	logic [NUM_CHANNELS-1:0] open_q;
	logic [LW-1:0]           fname_cnt_q [NUM_CHANNELS];
	logic [CW-1:0]           widx;
	logic [CW-1:0]           ridx;

	assign widx         = req.chan[CW-1:0];
	assign ridx         = rd_chan[CW-1:0];
	assign rd_fname_cnt = fname_cnt_q[ridx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) fname_cnt_q[i] <= '0;
		end else if (upd) begin
			if (req.clear_all) begin
				open_q <= '0;
				for (int i = 0; i < NUM_CHANNELS; i++) fname_cnt_q[i] <= '0;
			end else if (req.open_en) begin
				open_q[widx]      <= 1'b1;
				fname_cnt_q[widx] <= '0;
			end else if (req.close_en) begin
				open_q[widx] <= 1'b0;
			end else if (req.name_inc) begin
				fname_cnt_q[widx] <= fname_cnt_q[widx] + 1'b1;
			end
		end
	end

`ifndef SYNTH
	// name bytes are only taken on a channel that an open made live
	a_name_on_open: assert property (@(posedge clk) disable iff (!arst_n)
		upd && req.name_inc |-> open_q[widx])
		else $error("name byte stored on a closed channel");

	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		upd && req.clear_all |=> open_q == '0)
		else $error("interface clear left a channel open");

	a_open_resets_len: assert property (@(posedge clk) disable iff (!arst_n)
		upd && req.open_en && !req.clear_all |=> fname_cnt_q[$past(widx)] == '0)
		else $error("open did not restart the filename");
`endif

endmodule
`default_nettype wire
